// ----- hw/rtl/hsl_pkg.sv -----
// shared constants, types and pipeline control struct for the hsl to rgb converter
// no dependencies
package hsl_pkg;

  // field widths
  localparam int HUE_FRAC_BITS = 4;
  localparam int HUE_W         = 13;
  localparam int FRAC_W        = 8;
  localparam int CH_W          = 8;

  // one hue sector (60 degrees) in hue units
  localparam int SECTOR        = 60 << HUE_FRAC_BITS;
  localparam int POS_W         = $clog2(2 * SECTOR);
  localparam int XN_W          = $clog2(SECTOR + 1);
  localparam int FRAC_ONE      = 255;

  // hue / SECTOR by reciprocal, one correction step afterwards
  localparam int HUE_RSHIFT    = 20;
  localparam int HUE_PROD_W    = 24;
  localparam int HUE_Q_W       = 4;
  localparam logic [10:0] HUE_RECIP = 11'((1 << HUE_RSHIFT) / SECTOR);

  // chroma numerator, weight and product widths
  localparam int CN_W          = 16;
  localparam int T_W           = 11;
  localparam int P_W           = 28;

  // channel offset from lightness is floor(P / (2 * FRAC_ONE * SECTOR))
  localparam int DIV_FULL      = 2 * FRAC_ONE * SECTOR;
  localparam int DIV_SHIFT     = 7;
  localparam int DIV_ODD       = DIV_FULL >> DIV_SHIFT;
  localparam int DIV_BIAS      = 128;
  localparam int DIV_BIAS_ADD  = DIV_BIAS * DIV_ODD;
  localparam int PP_W          = 20;
  localparam int DIV_RSHIFT    = 32;
  localparam int DIV_PROD_W    = 41;
  localparam logic [20:0] DIV_RECIP = 21'((64'd1 << DIV_RSHIFT) / DIV_ODD);
  localparam int DQ_W          = 8;
  localparam int DR_W          = 13;

  localparam int NSTAGES       = 8;

  // stage enables and stage valids, shared by every datapath module
  typedef struct packed {
    logic [NSTAGES-1:0] en;
    logic [NSTAGES-1:0] vld;
  } hsl_ctl_t;

  // hand-over from the hue decode to the channel lanes
  typedef struct packed {
    logic [CN_W-1:0]       cn;
    logic [FRAC_W-1:0]     light;
    logic signed [T_W-1:0] t_r;
    logic signed [T_W-1:0] t_g;
    logic signed [T_W-1:0] t_b;
  } hsl_mid_t;

endpackage

// ----- hw/rtl/hsl_sector.sv -----
// hue decode and chroma: stages 0 to 2 of the converter pipeline
// depends on hsl_pkg
module hsl_sector (
  input  logic                         clk,
  input  hsl_pkg::hsl_ctl_t            ctl,
  input  logic [hsl_pkg::HUE_W-1:0]    hue,
  input  logic [hsl_pkg::FRAC_W-1:0]   sat,
  input  logic [hsl_pkg::FRAC_W-1:0]   light,
  output hsl_pkg::hsl_mid_t            mid
);
  import hsl_pkg::*;

  typedef enum logic [2:0] {
    SEC_RY, SEC_YG, SEC_GC, SEC_CB, SEC_BM, SEC_MR
  } hsl_sector_t;

  // stage 0
  logic [HUE_PROD_W-1:0] a_hprod_r, a_hprod_nxt;
  logic [HUE_W-1:0]      a_hue_r;
  logic [CN_W-1:0]       a_cn_r, a_cn_nxt;
  logic [FRAC_W-1:0]     a_l_r;
  logic [FRAC_W:0]       two_l;
  logic [FRAC_W:0]       l_dev;
  logic [FRAC_W-1:0]     cw;

  // stage 1
  logic [HUE_Q_W-1:0]    b_q_r, b_q_nxt;
  logic [POS_W-1:0]      b_r0_r, b_r0_nxt;
  logic [CN_W-1:0]       b_cn_r;
  logic [FRAC_W-1:0]     b_l_r;

  // stage 2
  hsl_mid_t              c_mid_r, c_mid_nxt;
  logic [HUE_Q_W-1:0]    q_fix;
  logic [POS_W-1:0]      r_fix;
  logic [XN_W-1:0]       xn;
  logic signed [T_W-1:0] tx;
  hsl_sector_t           sec;

  always_comb begin
    two_l = {light, 1'b0};
    // |2l - 255|
    if (light[FRAC_W-1]) begin
      l_dev = two_l - (FRAC_W+1)'(FRAC_ONE);
    end else begin
      l_dev = (FRAC_W+1)'(FRAC_ONE) - two_l;
    end
    cw          = FRAC_W'(FRAC_ONE) - l_dev[FRAC_W-1:0];
    a_cn_nxt    = CN_W'(cw) * CN_W'(sat);
    a_hprod_nxt = HUE_PROD_W'(hue) * HUE_PROD_W'(HUE_RECIP);
  end

  always_comb begin
    b_q_nxt  = a_hprod_r[HUE_RSHIFT +: HUE_Q_W];
    b_r0_nxt = POS_W'(a_hue_r - HUE_W'(b_q_nxt) * HUE_W'(SECTOR));
  end

  always_comb begin
    if (b_r0_r >= POS_W'(SECTOR)) begin
      q_fix = b_q_r + HUE_Q_W'(1);
      r_fix = b_r0_r - POS_W'(SECTOR);
    end else begin
      q_fix = b_q_r;
      r_fix = b_r0_r;
    end
    // rising or falling half of the double sector
    if (q_fix[0]) begin
      xn = XN_W'(SECTOR) - XN_W'(r_fix);
    end else begin
      xn = XN_W'(r_fix);
    end
    tx = T_W'({xn, 1'b0}) - T_W'(SECTOR);
    // hue of 360 degrees or more stays in the last sector
    if (q_fix > HUE_Q_W'(SEC_MR)) begin
      sec = SEC_MR;
    end else begin
      sec = hsl_sector_t'(q_fix[2:0]);
    end
    c_mid_nxt.cn    = b_cn_r;
    c_mid_nxt.light = b_l_r;
    unique case (sec)
      SEC_RY: begin
        c_mid_nxt.t_r = T_W'(SECTOR);  c_mid_nxt.t_g = tx;  c_mid_nxt.t_b = -T_W'(SECTOR);
      end
      SEC_YG: begin
        c_mid_nxt.t_r = tx;  c_mid_nxt.t_g = T_W'(SECTOR);  c_mid_nxt.t_b = -T_W'(SECTOR);
      end
      SEC_GC: begin
        c_mid_nxt.t_r = -T_W'(SECTOR);  c_mid_nxt.t_g = T_W'(SECTOR);  c_mid_nxt.t_b = tx;
      end
      SEC_CB: begin
        c_mid_nxt.t_r = -T_W'(SECTOR);  c_mid_nxt.t_g = tx;  c_mid_nxt.t_b = T_W'(SECTOR);
      end
      SEC_BM: begin
        c_mid_nxt.t_r = tx;  c_mid_nxt.t_g = -T_W'(SECTOR);  c_mid_nxt.t_b = T_W'(SECTOR);
      end
      default: begin
        c_mid_nxt.t_r = T_W'(SECTOR);  c_mid_nxt.t_g = -T_W'(SECTOR);  c_mid_nxt.t_b = tx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      a_hprod_r <= a_hprod_nxt;
      a_hue_r   <= hue;
      a_cn_r    <= a_cn_nxt;
      a_l_r     <= light;
    end
    if (ctl.en[1]) begin
      b_q_r  <= b_q_nxt;
      b_r0_r <= b_r0_nxt;
      b_cn_r <= a_cn_r;
      b_l_r  <= a_l_r;
    end
    if (ctl.en[2]) begin
      c_mid_r <= c_mid_nxt;
    end
  end

  assign mid = c_mid_r;

`ifndef SYNTHESIS
  // reciprocal estimate never overshoots the true sector
  a_hue_sector_est: assert property (@(posedge clk)
    ctl.vld[0] |-> (HUE_W'(a_hprod_r[HUE_RSHIFT +: HUE_Q_W]) * HUE_W'(SECTOR)) <= a_hue_r)
    else $error("hue sector estimate too large");
  // and undershoots by at most one sector
  a_hue_rem_range: assert property (@(posedge clk)
    ctl.vld[1] |-> b_r0_r < POS_W'(2 * SECTOR))
    else $error("hue remainder out of range");
`endif

endmodule

// ----- hw/rtl/hsl_chan.sv -----
// one colour channel lane: weight multiply, scaling division and clamp, stages 3 to 7
// depends on hsl_pkg
module hsl_chan (
  input  logic                            clk,
  input  hsl_pkg::hsl_ctl_t               ctl,
  input  logic [hsl_pkg::CN_W-1:0]        cn,
  input  logic [hsl_pkg::FRAC_W-1:0]      light,
  input  logic signed [hsl_pkg::T_W-1:0]  t,
  output logic [hsl_pkg::CH_W-1:0]        chan
);
  import hsl_pkg::*;

  logic signed [P_W-1:0]  cn_ext, t_ext;
  logic signed [P_W-1:0]  d_p_r, d_p_nxt;
  logic [FRAC_W-1:0]      d_l_r;
  logic signed [P_W-1:0]  p_bias;
  logic [PP_W-1:0]        e_pp_r;
  logic [FRAC_W-1:0]      e_l_r;
  logic [DIV_PROD_W-1:0]  f_prod_r, f_prod_nxt;
  logic [PP_W-1:0]        f_pp_r;
  logic [FRAC_W-1:0]      f_l_r;
  logic [DQ_W-1:0]        g_q_r, g_q_nxt;
  logic [DR_W-1:0]        g_r_r, g_r_nxt;
  logic [FRAC_W-1:0]      g_l_r;
  logic [DQ_W:0]          q_fix;
  logic signed [FRAC_W+2:0] sum;
  logic [CH_W-1:0]        chan_r, chan_nxt;

  always_comb begin
    cn_ext  = P_W'({1'b0, cn});
    t_ext   = P_W'(t);
    d_p_nxt = cn_ext * t_ext;
  end

  // floor division: arithmetic shift, then biased unsigned divide by the odd part
  assign p_bias = (d_p_r >>> DIV_SHIFT) + P_W'(DIV_BIAS_ADD);

  assign f_prod_nxt = DIV_PROD_W'(e_pp_r) * DIV_PROD_W'(DIV_RECIP);

  always_comb begin
    g_q_nxt = f_prod_r[DIV_RSHIFT +: DQ_W];
    g_r_nxt = DR_W'(f_pp_r - PP_W'(g_q_nxt) * PP_W'(DIV_ODD));
  end

  always_comb begin
    if (g_r_r >= DR_W'(DIV_ODD)) begin
      q_fix = {1'b0, g_q_r} + (DQ_W+1)'(1);
    end else begin
      q_fix = {1'b0, g_q_r};
    end
    sum = (FRAC_W+3)'(g_l_r) + (FRAC_W+3)'(q_fix) - (FRAC_W+3)'(DIV_BIAS);
    if (sum < 0) begin
      chan_nxt = '0;
    end else if (sum > (FRAC_W+3)'((1 << CH_W) - 1)) begin
      chan_nxt = '1;
    end else begin
      chan_nxt = sum[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      d_p_r <= d_p_nxt;
      d_l_r <= light;
    end
    if (ctl.en[4]) begin
      e_pp_r <= p_bias[PP_W-1:0];
      e_l_r  <= d_l_r;
    end
    if (ctl.en[5]) begin
      f_prod_r <= f_prod_nxt;
      f_pp_r   <= e_pp_r;
      f_l_r    <= e_l_r;
    end
    if (ctl.en[6]) begin
      g_q_r <= g_q_nxt;
      g_r_r <= g_r_nxt;
      g_l_r <= f_l_r;
    end
    if (ctl.en[7]) begin
      chan_r <= chan_nxt;
    end
  end

  assign chan = chan_r;

`ifndef SYNTHESIS
  // reciprocal quotient is short by at most one
  a_div_rem_range: assert property (@(posedge clk)
    ctl.vld[6] |-> g_r_r < DR_W'(2 * DIV_ODD))
    else $error("channel remainder out of range");
`endif

endmodule

// ----- hw/rtl/hsl_to_rgb_converter.sv -----
// top level of the hsl to rgb converter: handshake, stage valids and three channel lanes
// depends on hsl_pkg, hsl_sector and hsl_chan
//
// Converts one HSL colour per transfer into an 8-bit RGB triple. Hue is in 1/16 degree
// (0 to 8191, values of 360 degrees and above map into the magenta-to-red sector),
// saturation and lightness are 8-bit fractions with 255 meaning one. Every channel is
// the exact rational result truncated toward zero and clamped to 0..255. The datapath
// is an eight-stage pipeline: three stages decode the hue sector and chroma, then
// three identical lanes multiply, divide by a constant through a reciprocal and clamp;
// each stage carries at most one multiplier on any one path. One colour is taken every
// clock cycle while the output side keeps up. Every stage has its own valid bit and
// advances whenever the stage after it is empty or moving, so a stalled output only
// holds back as many items as are queued behind it and empty stages still fill. There
// are no configuration registers and no state beyond the pipeline.
module hsl_to_rgb_converter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hsl_pkg::HUE_W-1:0]     in_hue,
  input  logic [hsl_pkg::FRAC_W-1:0]    in_saturation,
  input  logic [hsl_pkg::FRAC_W-1:0]    in_lightness,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hsl_pkg::CH_W-1:0]      out_red,
  output logic [hsl_pkg::CH_W-1:0]      out_green,
  output logic [hsl_pkg::CH_W-1:0]      out_blue
);
  import hsl_pkg::*;

  logic [NSTAGES-1:0] v_r, v_nxt;
  logic [NSTAGES-1:0] en;
  hsl_ctl_t           ctl;
  hsl_mid_t           mid;

  // a stage may load when it is empty or its contents move on
  always_comb begin
    en[NSTAGES-1] = !v_r[NSTAGES-1] || out_ready;
    for (int i = NSTAGES - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (en[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int i = 1; i < NSTAGES; i++) begin
      if (en[i]) begin
        v_nxt[i] = v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign ctl.en  = en;
  assign ctl.vld = v_r;

  assign in_ready  = en[0];
  assign out_valid = v_r[NSTAGES-1];

  // sector decode and chroma
  hsl_sector u_sector (
    .clk   (clk),
    .ctl   (ctl),
    .hue   (in_hue),
    .sat   (in_saturation),
    .light (in_lightness),
    .mid   (mid)
  );

  // one lane per output channel
  hsl_chan u_chan_r (
    .clk   (clk),
    .ctl   (ctl),
    .cn    (mid.cn),
    .light (mid.light),
    .t     (mid.t_r),
    .chan  (out_red)
  );

  hsl_chan u_chan_g (
    .clk   (clk),
    .ctl   (ctl),
    .cn    (mid.cn),
    .light (mid.light),
    .t     (mid.t_g),
    .chan  (out_green)
  );

  hsl_chan u_chan_b (
    .clk   (clk),
    .ctl   (ctl),
    .cn    (mid.cn),
    .light (mid.light),
    .t     (mid.t_b),
    .chan  (out_blue)
  );

`ifndef SYNTHESIS
  // input is only refused when every stage is occupied
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r))
    else $error("input refused with an empty stage");
  // the last internal stage moves into the output register when it is being drained
  a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NSTAGES-2] && out_ready) |=> out_valid)
    else $error("item lost before the output register");
`endif

endmodule
